// ===== rtl/lrpa_pkg.sv =====
// shared types, widths and register codes for the line rasterizer
// used by lrpa_addr_gen and line_rasterizer_with_pixel_address
`default_nettype none

package lrpa_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PITCH_W    = 16;
  localparam int unsigned BPP_W      = 3;
  localparam int unsigned FRAME_W    = 12;

  // line state widths
  localparam int unsigned TWICE_W = COORD_BITS + 1;
  localparam int unsigned ERR_W   = COORD_BITS + 3;
  localparam int unsigned LEFT_W  = COORD_BITS + 1;

  // clip compare width
  localparam int unsigned CMP_W = (COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W;

  // stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((4 * COORD_BITS + 24 + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((ADDR_W + 2 * COORD_BITS + COLOR_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration reset values
  localparam logic [ADDR_W-1:0]  RST_BASE   = '0;
  localparam logic [PITCH_W-1:0] RST_PITCH  = PITCH_W'(7680);
  localparam logic [BPP_W-1:0]   RST_BPP    = BPP_W'(4);
  localparam logic [FRAME_W-1:0] RST_WIDTH  = FRAME_W'(1920);
  localparam logic [FRAME_W-1:0] RST_HEIGHT = FRAME_W'(1080);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE   = 3'd0,
    REG_PITCH  = 3'd1,
    REG_BPP    = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    MODE_START   = 1'b0,
    MODE_ADVANCE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [PITCH_W-1:0] pitch;
    logic [BPP_W-1:0]   bpp;
    logic [FRAME_W-1:0] width;
    logic [FRAME_W-1:0] height;
  } frame_cfg_t;

  typedef struct packed {
    logic              write;
    logic [ADDR_W-1:0] addr;
  } pix_addr_t;

endpackage

`default_nettype wire

// ===== rtl/lrpa_addr_gen.sv =====
// frame buffer byte address and clip test for one pixel
// depends on lrpa_pkg
`default_nettype none

module lrpa_addr_gen
  import lrpa_pkg::*;
(
  input  frame_cfg_t cfg_i,
  input  coord_t     x_i,
  input  coord_t     y_i,
  output pix_addr_t  pix_o
);

  localparam int unsigned PY_W = COORD_BITS + PITCH_W + 1;
  localparam int unsigned PX_W = COORD_BITS + BPP_W + 1;

  logic signed [PY_W-1:0] prod_y;
  logic signed [PX_W-1:0] prod_x;
  logic [CMP_W-1:0]       x_u;
  logic [CMP_W-1:0]       y_u;

  // signed coordinate times unsigned scale, wrapped to the address width
  assign prod_y = y_i * $signed({1'b0, cfg_i.pitch});
  assign prod_x = x_i * $signed({1'b0, cfg_i.bpp});

  assign pix_o.addr = cfg_i.base + ADDR_W'(prod_y) + ADDR_W'(prod_x);

  assign x_u = CMP_W'($unsigned(x_i));
  assign y_u = CMP_W'($unsigned(y_i));

  assign pix_o.write = !x_i[COORD_BITS-1] && !y_i[COORD_BITS-1]
                     && (x_u < CMP_W'(cfg_i.width))
                     && (y_u < CMP_W'(cfg_i.height));

endmodule

`default_nettype wire

// ===== rtl/line_rasterizer_with_pixel_address.sv =====
// line rasterizer top level: request stream in, pixel stream out, config port
// depends on lrpa_pkg and lrpa_addr_gen
//
// usage
//   s_axis carries requests: tuser[0] is the mode (0 start a line, 1 advance
//   to the next pixel), tdata the endpoints and the color
//   m_axis carries one pixel per request: tuser holds the line-active and
//   write-enable flags, tdata the byte address, coordinates and color word,
//   tlast marks the final pixel of a line
//   the cfg port writes the frame registers by index; it is always ready and
//   must only be used while no request is in flight
// timing
//   a request goes from the input register to the result register, from which
//   its pixel leaves; one request per cycle is sustained while m_axis_tready is
//   high, with the single Bresenham step and the 12x17 row multiply in between
// reset
//   rst_ni clears both pipeline stages and the line state (no line active);
//   the frame registers return to base 0, pitch 7680, 4 bytes per pixel,
//   1920 x 1080
// backpressure
//   while m_axis_tready is low the result register holds and the input
//   register still takes one more request; s_axis_tready drops only when
//   both are full
`default_nettype none

module line_rasterizer_with_pixel_address
  import lrpa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // start_x, start_y, end_x, end_y, color_red, color_green, color_blue
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic                  s_axis_tuser,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_address, pixel_x, pixel_y, pixel_value
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // line_active, pixel_write
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  // last_pixel
  output logic                  m_axis_tlast,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned C = COORD_BITS;

  // ---------------------------------------------------------------------------
  // frame registers
  // ---------------------------------------------------------------------------
  frame_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base   <= RST_BASE;
      cfg_q.pitch  <= RST_PITCH;
      cfg_q.bpp    <= RST_BPP;
      cfg_q.width  <= RST_WIDTH;
      cfg_q.height <= RST_HEIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BASE:   cfg_q.base   <= cfg_data_i[ADDR_W-1:0];
        REG_PITCH:  cfg_q.pitch  <= cfg_data_i[PITCH_W-1:0];
        REG_BPP:    cfg_q.bpp    <= cfg_data_i[BPP_W-1:0];
        REG_WIDTH:  cfg_q.width  <= cfg_data_i[FRAME_W-1:0];
        REG_HEIGHT: cfg_q.height <= cfg_data_i[FRAME_W-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline handshake
  // ---------------------------------------------------------------------------
  logic                 in_valid_q;
  logic [IN_DATA_W-1:0] in_data_q;
  mode_e                in_mode_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 advance;
  logic                 in_take;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
      in_mode_q <= mode_e'(s_axis_tuser);
    end
  end

  // ---------------------------------------------------------------------------
  // line setup from a start request
  // ---------------------------------------------------------------------------
  coord_t              x0, y0, x1, y1;
  logic [COLOR_W-1:0]  color_in;
  logic signed [C:0]   dx_full, dy_full;
  logic [C:0]          adx_ext, ady_ext;
  logic [C-1:0]        adx, ady, major, minor;
  logic                x_major_new;

  function automatic coord_t s_axis_tdata_unused_guard(input logic [IN_DATA_W-1:0] d,
                                                      input int unsigned k);
    return coord_t'(d[k*C +: C]);
  endfunction

  assign x0 = s_axis_tdata_unused_guard(in_data_q, 0);
  assign y0 = s_axis_tdata_unused_guard(in_data_q, 1);
  assign x1 = s_axis_tdata_unused_guard(in_data_q, 2);
  assign y1 = s_axis_tdata_unused_guard(in_data_q, 3);

  // packed as red << 16 | green << 8 | blue
  assign color_in = {in_data_q[4*C +: 8], in_data_q[4*C+8 +: 8], in_data_q[4*C+16 +: 8]};

  assign dx_full = {x1[C-1], x1} - {x0[C-1], x0};
  assign dy_full = {y1[C-1], y1} - {y0[C-1], y0};
  assign adx_ext = dx_full[C] ? (C+1)'(-dx_full) : $unsigned(dx_full);
  assign ady_ext = dy_full[C] ? (C+1)'(-dy_full) : $unsigned(dy_full);
  assign adx     = adx_ext[C-1:0];
  assign ady     = ady_ext[C-1:0];

  // tie goes to y as the major axis
  assign x_major_new = adx > ady;
  assign major       = x_major_new ? adx : ady;
  assign minor       = x_major_new ? ady : adx;

  // ---------------------------------------------------------------------------
  // line state
  // ---------------------------------------------------------------------------
  logic               busy_q, busy_d;
  coord_t             cur_x_q, cur_x_d;
  coord_t             cur_y_q, cur_y_d;
  logic               sx_neg_q, sx_neg_d;
  logic               sy_neg_q, sy_neg_d;
  logic               x_major_q, x_major_d;
  logic [ERR_W-1:0]   err_q, err_d;
  logic [TWICE_W-1:0] tmaj_q, tmaj_d;
  logic [TWICE_W-1:0] tmin_q, tmin_d;
  logic [LEFT_W-1:0]  left_q, left_d;
  logic [COLOR_W-1:0] color_q, color_d;

  // state the pixel is drawn from: freshly set up or carried over
  logic               is_start;
  logic               emit;
  coord_t             ex, ey;
  logic               e_sxn, e_syn, e_xmaj;
  logic [ERR_W-1:0]   e_err, err_sub, err_fix;
  logic [TWICE_W-1:0] e_tmaj, e_tmin;
  logic [LEFT_W-1:0]  e_left, left_dec;
  logic [COLOR_W-1:0] e_color;
  logic               last;
  logic               minor_step;
  coord_t             x_step, y_step;

  assign is_start = (in_mode_q == MODE_START);
  assign emit     = is_start || busy_q;

  always_comb begin
    if (is_start) begin
      ex      = x0;
      ey      = y0;
      e_sxn   = dx_full[C];
      e_syn   = dy_full[C];
      e_xmaj  = x_major_new;
      e_err   = ERR_W'(major);
      e_tmaj  = {major, 1'b0};
      e_tmin  = {minor, 1'b0};
      e_left  = LEFT_W'(major) + LEFT_W'(1);
      e_color = color_in;
    end else begin
      ex      = cur_x_q;
      ey      = cur_y_q;
      e_sxn   = sx_neg_q;
      e_syn   = sy_neg_q;
      e_xmaj  = x_major_q;
      e_err   = err_q;
      e_tmaj  = tmaj_q;
      e_tmin  = tmin_q;
      e_left  = left_q;
      e_color = color_q;
    end
  end

  // one Bresenham step
  assign left_dec   = (e_left != '0) ? e_left - LEFT_W'(1) : e_left;
  assign last       = (left_dec == '0);
  assign err_sub    = e_err - ERR_W'(e_tmin);
  assign minor_step = err_sub[ERR_W-1];
  assign err_fix    = minor_step ? err_sub + ERR_W'(e_tmaj) : err_sub;
  assign x_step     = e_sxn ? ex - coord_t'(1) : ex + coord_t'(1);
  assign y_step     = e_syn ? ey - coord_t'(1) : ey + coord_t'(1);

  always_comb begin
    busy_d    = busy_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    sx_neg_d  = sx_neg_q;
    sy_neg_d  = sy_neg_q;
    x_major_d = x_major_q;
    err_d     = err_q;
    tmaj_d    = tmaj_q;
    tmin_d    = tmin_q;
    left_d    = left_q;
    color_d   = color_q;
    if (advance && emit) begin
      busy_d    = !last;
      sx_neg_d  = e_sxn;
      sy_neg_d  = e_syn;
      x_major_d = e_xmaj;
      tmaj_d    = e_tmaj;
      tmin_d    = e_tmin;
      left_d    = left_dec;
      color_d   = e_color;
      if (last) begin
        // final pixel: position and error stay where they are
        cur_x_d = ex;
        cur_y_d = ey;
        err_d   = e_err;
      end else begin
        err_d   = err_fix;
        cur_x_d = (e_xmaj || minor_step) ? x_step : ex;
        cur_y_d = (!e_xmaj || minor_step) ? y_step : ey;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      sx_neg_q  <= 1'b0;
      sy_neg_q  <= 1'b0;
      x_major_q <= 1'b0;
      err_q     <= '0;
      tmaj_q    <= '0;
      tmin_q    <= '0;
      left_q    <= '0;
      color_q   <= '0;
    end else begin
      busy_q    <= busy_d;
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      sx_neg_q  <= sx_neg_d;
      sy_neg_q  <= sy_neg_d;
      x_major_q <= x_major_d;
      err_q     <= err_d;
      tmaj_q    <= tmaj_d;
      tmin_q    <= tmin_d;
      left_q    <= left_d;
      color_q   <= color_d;
    end
  end

  // ---------------------------------------------------------------------------
  // address, clip and result register
  // ---------------------------------------------------------------------------
  pix_addr_t pix;

  lrpa_addr_gen u_addr_gen (
    .cfg_i (cfg_q),
    .x_i   (ex),
    .y_i   (ey),
    .pix_o (pix)
  );

  logic [OUT_DATA_W-1:0] res_data_q, res_data_d;
  logic [OUT_USER_W-1:0] res_user_q, res_user_d;
  logic                  res_last_q, res_last_d;

  always_comb begin
    res_data_d = '0;
    res_user_d = '0;
    res_last_d = 1'b0;
    // an advance with no line gives an all-zero result
    if (emit) begin
      res_data_d = OUT_DATA_W'({e_color, ey, ex, pix.addr});
      res_user_d = {pix.write, 1'b1};
      res_last_d = last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_data_q <= res_data_d;
      res_user_q <= res_user_d;
      res_last_q <= res_last_d;
    end
  end

  assign m_axis_tdata = res_data_q;
  assign m_axis_tuser = res_user_q;
  assign m_axis_tlast = res_last_q;

`ifndef NO_ASSERTIONS
  // a line is in progress exactly while pixels remain
  a_busy_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (left_q != '0))
    else $error("line busy flag disagrees with pixel count");

  // a start request always yields an active pixel
  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_mode_q == MODE_START) |=> m_axis_tuser[0])
    else $error("start request gave no active pixel");

  // an idle result carries nothing
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      (m_axis_tdata == '0) && !m_axis_tuser[1] && !m_axis_tlast)
    else $error("idle result carries data");

  // last pixel leaves the block idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit && last |=> !busy_q)
    else $error("line still busy after last pixel");
`endif

endmodule

`default_nettype wire
